@@ sv/tsrs_pkg.sv @@
package tsrs_pkg;

    localparam int QFrac    = 28;
    localparam int NumSteps = 14;
    localparam int StepW    = $clog2(NumSteps);
    localparam int AddrW    = 5;

    localparam logic [2:0] REG_RATE_START  = 3'd0;
    localparam logic [2:0] REG_REVERSION_1 = 3'd1;
    localparam logic [2:0] REG_REVERSION_2 = 3'd2;
    localparam logic [2:0] REG_TIME_STEP   = 3'd3;
    localparam logic [2:0] REG_ROOT_STEP   = 3'd4;
    localparam logic [2:0] REG_CORR        = 3'd5;
    localparam logic [2:0] REG_CORR_COMPL  = 3'd6;
    localparam logic [2:0] REG_STEPS       = 3'd7;

    // multiplier operand A
    typedef enum logic [3:0] {
        MA_ROOT, MA_COMPL, MA_REV1, MA_CORR, MA_SCALE,
        MA_TEMP, MA_SIG1, MA_REV2, MA_SIG2
    } mul_a_sel_t;

    // multiplier operand B
    typedef enum logic [2:0] {
        MB_NOISE1, MB_ROOT, MB_FAC1, MB_WIENER1,
        MB_NOISE2, MB_DT, MB_WIENER2, MB_FAC2
    } mul_b_sel_t;

    // adder operand A
    typedef enum logic [2:0] {
        AA_ZERO, AA_FAC1, AA_FAC2, AA_WIENER2, AA_TEMP, AA_RATE0
    } alu_a_sel_t;

    // adder operand B
    typedef enum logic [1:0] {
        AB_PROD, AB_SCALE, AB_FAC1, AB_FAC2
    } alu_b_sel_t;

    typedef enum logic [2:0] {
        DST_NONE, DST_WIENER1, DST_SCALE, DST_WIENER2,
        DST_TEMP, DST_FAC1, DST_FAC2
    } dst_sel_t;

    typedef enum logic {
        SEQ_NEXT, SEQ_FINISH
    } seq_op_t;

    typedef struct packed {
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
        alu_a_sel_t alu_a;
        alu_b_sel_t alu_b;
        logic       alu_neg;
        dst_sel_t   dst;
        seq_op_t    seq;
    } micro_word_t;

    // Microprogram. A product formed in step i is written back in step i+1.
    function automatic micro_word_t micro_rom(input logic [StepW-1:0] step);
        micro_word_t w;
        w = '{MA_ROOT, MB_NOISE1, AA_ZERO, AB_PROD, 1'b0, DST_NONE, SEQ_NEXT};
        unique case (step)
            4'd0:  w = '{MA_ROOT,  MB_NOISE1,  AA_ZERO,  AB_PROD,  1'b0, DST_NONE,    SEQ_NEXT};
            4'd1:  w = '{MA_COMPL, MB_ROOT,    AA_ZERO,  AB_PROD,  1'b0, DST_WIENER1, SEQ_NEXT};
            4'd2:  w = '{MA_REV1,  MB_FAC1,    AA_ZERO,  AB_PROD,  1'b0, DST_SCALE,   SEQ_NEXT};
            4'd3:  w = '{MA_CORR,  MB_WIENER1, AA_ZERO,  AB_PROD,  1'b0, DST_TEMP,    SEQ_NEXT};
            4'd4:  w = '{MA_SCALE, MB_NOISE2,  AA_ZERO,  AB_PROD,  1'b0, DST_WIENER2, SEQ_NEXT};
            4'd5:  w = '{MA_TEMP,  MB_DT,      AA_WIENER2, AB_PROD, 1'b0, DST_WIENER2, SEQ_NEXT};
            4'd6:  w = '{MA_SIG1,  MB_WIENER1, AA_FAC1,  AB_PROD,  1'b1, DST_FAC1,    SEQ_NEXT};
            4'd7:  w = '{MA_REV2,  MB_FAC2,    AA_FAC1,  AB_PROD,  1'b0, DST_FAC1,    SEQ_NEXT};
            4'd8:  w = '{MA_SIG2,  MB_WIENER2, AA_ZERO,  AB_PROD,  1'b0, DST_TEMP,    SEQ_NEXT};
            4'd9:  w = '{MA_TEMP,  MB_DT,      AA_ZERO,  AB_PROD,  1'b0, DST_SCALE,   SEQ_NEXT};
            4'd10: w = '{MA_ROOT,  MB_NOISE1,  AA_FAC2,  AB_PROD,  1'b1, DST_FAC2,    SEQ_NEXT};
            4'd11: w = '{MA_ROOT,  MB_NOISE1,  AA_FAC2,  AB_SCALE, 1'b0, DST_FAC2,    SEQ_NEXT};
            4'd12: w = '{MA_ROOT,  MB_NOISE1,  AA_RATE0, AB_FAC1,  1'b0, DST_TEMP,    SEQ_NEXT};
            4'd13: w = '{MA_ROOT,  MB_NOISE1,  AA_TEMP,  AB_FAC2,  1'b0, DST_NONE,    SEQ_FINISH};
            default: w = '{MA_ROOT, MB_NOISE1, AA_ZERO,  AB_PROD,  1'b0, DST_NONE,    SEQ_FINISH};
        endcase
        return w;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

@@ sv/two_factor_short_rate_step.sv @@
// One Euler-Maruyama step of a two-factor G2++ short-rate path in signed
// Q4.28 with saturation. Each item (noise_one, noise_two, sigma_one,
// sigma_two) yields one result: short_rate = max(r0 + x + y, 0) and
// last_of_path, after which the factors and step count return to zero.
// From acceptance to its result an item is carried by a microprogram of
// 14 control words that steps one shared 32x32 multiplier (registered
// product) and one saturating adder through the ten products and the
// sums of the update. item_stall is high while a step is in work, so the
// next item can enter in the cycle in which the result appears, and no new
// item is taken before then. The result register lets the next item enter
// while a result waits.
// The result step holds until the result register is free. Registers sit on
// an APB port at byte address 4*i; configure only while the block is idle.
module two_factor_short_rate_step (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic signed [31:0]                 noise_one,
    input  logic signed [31:0]                 noise_two,
    input  logic [30:0]                        sigma_one,
    input  logic [30:0]                        sigma_two,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [30:0]                        short_rate,
    output logic                               last_of_path,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsrs_pkg::AddrW-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tsrs_pkg::*;

    // configuration registers
    logic signed [31:0] rate_start_reg;
    logic [30:0]        reversion_one_reg;
    logic [30:0]        reversion_two_reg;
    logic [30:0]        time_step_reg;
    logic [30:0]        root_time_step_reg;
    logic signed [29:0] correlation_reg;
    logic [28:0]        correlation_complement_reg;
    logic [24:0]        steps_per_path_reg;

    // captured item
    logic signed [31:0] noise_one_reg;
    logic signed [31:0] noise_two_reg;
    logic [30:0]        sigma_one_reg;
    logic [30:0]        sigma_two_reg;

    // path state and scratch registers
    logic signed [31:0] fac1_reg;
    logic signed [31:0] fac2_reg;
    logic [24:0]        step_count_reg;
    logic signed [31:0] wiener1_reg;
    logic signed [31:0] wiener2_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] temp_reg;
    logic signed [63:0] prod_reg;

    // sequencer
    logic               busy_reg;
    logic [StepW-1:0]   step_reg;

    // result register
    logic               result_valid_reg;
    logic [30:0]        short_rate_reg;
    logic               last_reg;

    micro_word_t        uw;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_rnd;
    logic signed [31:0] prod_q;
    logic signed [31:0] alu_a;
    logic signed [31:0] alu_b;
    logic signed [35:0] alu_sum;
    logic signed [31:0] alu_res;
    logic [25:0]        count_next;
    logic               path_end;
    logic               item_accept;
    logic               cfg_write;
    logic               out_free;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign item_stall  = busy_reg;
    assign item_accept = item_valid && !busy_reg;
    assign out_free    = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign short_rate   = short_rate_reg;
    assign last_of_path = last_reg;

    assign uw = micro_rom(step_reg);

    // Select multiplier operands.
    always_comb
    begin
        unique case (uw.mul_a)
            MA_ROOT:  mul_a = {1'b0, root_time_step_reg};
            MA_COMPL: mul_a = {3'b000, correlation_complement_reg};
            MA_REV1:  mul_a = {1'b0, reversion_one_reg};
            MA_CORR:  mul_a = {{2{correlation_reg[29]}}, correlation_reg};
            MA_SCALE: mul_a = scale_reg;
            MA_TEMP:  mul_a = temp_reg;
            MA_SIG1:  mul_a = {1'b0, sigma_one_reg};
            MA_REV2:  mul_a = {1'b0, reversion_two_reg};
            MA_SIG2:  mul_a = {1'b0, sigma_two_reg};
            default:  mul_a = '0;
        endcase
        unique case (uw.mul_b)
            MB_NOISE1:  mul_b = noise_one_reg;
            MB_ROOT:    mul_b = {1'b0, root_time_step_reg};
            MB_FAC1:    mul_b = fac1_reg;
            MB_WIENER1: mul_b = wiener1_reg;
            MB_NOISE2:  mul_b = noise_two_reg;
            MB_DT:      mul_b = {1'b0, time_step_reg};
            MB_WIENER2: mul_b = wiener2_reg;
            MB_FAC2:    mul_b = fac2_reg;
            default:    mul_b = '0;
        endcase
    end

    // Round the previous product half up, drop the fraction, clamp.
    assign prod_rnd = prod_reg + (64'sd1 <<< (QFrac - 1));
    assign prod_q   = sat32(prod_rnd[63:QFrac]);

    // Saturating add or subtract.
    always_comb
    begin
        unique case (uw.alu_a)
            AA_ZERO:    alu_a = '0;
            AA_FAC1:    alu_a = fac1_reg;
            AA_FAC2:    alu_a = fac2_reg;
            AA_WIENER2: alu_a = wiener2_reg;
            AA_TEMP:    alu_a = temp_reg;
            AA_RATE0:   alu_a = rate_start_reg;
            default:    alu_a = '0;
        endcase
        unique case (uw.alu_b)
            AB_PROD:  alu_b = prod_q;
            AB_SCALE: alu_b = scale_reg;
            AB_FAC1:  alu_b = fac1_reg;
            AB_FAC2:  alu_b = fac2_reg;
            default:  alu_b = '0;
        endcase
        if (uw.alu_neg)
        begin
            alu_sum = 36'(alu_a) - 36'(alu_b);
        end
        else
        begin
            alu_sum = 36'(alu_a) + 36'(alu_b);
        end
        alu_res = sat32(alu_sum);
    end

    assign count_next = {1'b0, step_count_reg} + 26'd1;
    assign path_end   = count_next >= {1'b0, steps_per_path_reg};

    // Register read-back.
    always_comb
    begin
        unique case (paddr[AddrW-1:2])
            REG_RATE_START:  prdata = rate_start_reg;
            REG_REVERSION_1: prdata = {1'b0, reversion_one_reg};
            REG_REVERSION_2: prdata = {1'b0, reversion_two_reg};
            REG_TIME_STEP:   prdata = {1'b0, time_step_reg};
            REG_ROOT_STEP:   prdata = {1'b0, root_time_step_reg};
            REG_CORR:        prdata = {{2{correlation_reg[29]}}, correlation_reg};
            REG_CORR_COMPL:  prdata = {3'b000, correlation_complement_reg};
            REG_STEPS:       prdata = {7'd0, steps_per_path_reg};
            default:         prdata = '0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_start_reg             <= '0;
            reversion_one_reg          <= '0;
            reversion_two_reg          <= '0;
            time_step_reg              <= '0;
            root_time_step_reg         <= '0;
            correlation_reg            <= '0;
            correlation_complement_reg <= 29'(1 << QFrac);
            steps_per_path_reg         <= 25'd1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[AddrW-1:2])
                REG_RATE_START:  rate_start_reg             <= pwdata;
                REG_REVERSION_1: reversion_one_reg          <= pwdata[30:0];
                REG_REVERSION_2: reversion_two_reg          <= pwdata[30:0];
                REG_TIME_STEP:   time_step_reg              <= pwdata[30:0];
                REG_ROOT_STEP:   root_time_step_reg         <= pwdata[30:0];
                REG_CORR:        correlation_reg            <= pwdata[29:0];
                REG_CORR_COMPL:  correlation_complement_reg <= pwdata[28:0];
                REG_STEPS:       steps_per_path_reg         <= pwdata[24:0];
                default:         ;
            endcase
        end
    end

    // Capture the item, hold the product and write the scratch registers; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            noise_one_reg <= noise_one;
            noise_two_reg <= noise_two;
            sigma_one_reg <= sigma_one;
            sigma_two_reg <= sigma_two;
        end
        prod_reg <= mul_a * mul_b;
        if (busy_reg)
        begin
            case (uw.dst)
                DST_WIENER1: wiener1_reg <= alu_res;
                DST_SCALE:   scale_reg   <= alu_res;
                DST_WIENER2: wiener2_reg <= alu_res;
                DST_TEMP:    temp_reg    <= alu_res;
                default:     ;
            endcase
        end
    end

    // Sequencer, path state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            step_reg         <= '0;
            fac1_reg         <= '0;
            fac2_reg         <= '0;
            step_count_reg   <= '0;
            result_valid_reg <= 1'b0;
            short_rate_reg   <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            // drop the result once taken
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (item_accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                case (uw.dst)
                    DST_FAC1: fac1_reg <= alu_res;
                    DST_FAC2: fac2_reg <= alu_res;
                    default:  ;
                endcase

                if (uw.seq == SEQ_NEXT)
                begin
                    step_reg <= step_reg + StepW'(1);
                end
                else if (out_free)
                begin
                    // finish: floor the rate at zero, close the path if due
                    result_valid_reg <= 1'b1;
                    short_rate_reg   <= alu_res[31] ? '0 : alu_res[30:0];
                    last_reg         <= path_end;
                    busy_reg         <= 1'b0;
                    step_reg         <= '0;
                    if (path_end)
                    begin
                        fac1_reg       <= '0;
                        fac2_reg       <= '0;
                        step_count_reg <= '0;
                    end
                    else
                    begin
                        step_count_reg <= count_next[24:0];
                    end
                end
            end
        end
    end

endmodule

@@ sv/tsrs_check.sv @@
module tsrs_check (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [30:0] short_rate,
    input logic        last_of_path
);

    // a waiting result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(short_rate) && $stable(last_of_path))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy through its program
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("block took a second item right away");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> ##13 item_stall)
        else $error("item finished too early");

    // a fresh result leaves the block free for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !item_stall)
        else $error("block still busy after delivering a result");

endmodule

bind two_factor_short_rate_step tsrs_check u_tsrs_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .short_rate   (short_rate),
    .last_of_path (last_of_path)
);

@@ bench/two_factor_short_rate_step_tb.sv @@
module two_factor_short_rate_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsrs_pkg::*;

    // Q4.28 corner values for the stimulus
    localparam logic signed [31:0] Q_ONE   = 32'sh1000_0000;
    localparam logic signed [31:0] N_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] N_MIN   = 32'sh8000_0000;
    localparam logic [30:0]        S_MAX   = 31'h7FFF_FFFF;
    localparam int                 LIMIT   = 200000;
    localparam int                 DRAIN   = 40;
    localparam longint             SAT_HI  = 64'sd2147483647;
    localparam longint             SAT_LO  = -64'sd2147483648;

    typedef struct packed {
        logic [30:0] rate;
        logic        path_end;
    } rate_result_t;

    // Shadow of the step datapath: registers, factors, step counter and the
    // queue of short rates still owed by the block.
    class short_rate_scoreboard;
        longint rate_start, reversion_one, reversion_two, time_step, root_time_step;
        longint correlation, correlation_compl, steps_per_path;
        longint factor_x, factor_y, step_count;
        rate_result_t rate_q[$];
        int errors, steps_seen, path_ends, reg_writes;

        function new();
            rate_start        = 0;
            reversion_one     = 0;
            reversion_two     = 0;
            time_step         = 0;
            root_time_step    = 0;
            correlation       = 0;
            correlation_compl = 64'sd268435456;
            steps_per_path    = 1;
            factor_x          = 0;
            factor_y          = 0;
            step_count        = 0;
            errors            = 0;
            steps_seen        = 0;
            path_ends         = 0;
            reg_writes        = 0;
        endfunction

        function longint clamp(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        // exact product, round half up, then saturate
        function longint fixed_mul(longint a, longint b);
            return clamp((a * b + 64'sd134217728) >>> 28);
        endfunction

        function longint sat_add(longint a, longint b);
            return clamp(a + b);
        endfunction

        function int pending();
            return rate_q.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            reg_writes++;
            case (idx)
                REG_RATE_START:  rate_start        = longint'(signed'(value));
                REG_REVERSION_1: reversion_one     = longint'(value[30:0]);
                REG_REVERSION_2: reversion_two     = longint'(value[30:0]);
                REG_TIME_STEP:   time_step         = longint'(value[30:0]);
                REG_ROOT_STEP:   root_time_step    = longint'(value[30:0]);
                REG_CORR:        correlation       = longint'(signed'(value[29:0]));
                REG_CORR_COMPL:  correlation_compl = longint'(value[28:0]);
                REG_STEPS:       steps_per_path    = longint'(value[24:0]);
                default: ;
            endcase
        endfunction

        function void note_item(logic signed [31:0] n1, logic signed [31:0] n2,
                                logic [30:0] s1, logic [30:0] s2);
            longint       shock_one, shock_two, scale_two, drift, rate;
            rate_result_t want;
            shock_one = fixed_mul(root_time_step, longint'(n1));
            scale_two = fixed_mul(correlation_compl, root_time_step);
            shock_two = sat_add(fixed_mul(correlation, shock_one),
                                fixed_mul(scale_two, longint'(n2)));

            drift    = fixed_mul(fixed_mul(reversion_one, factor_x), time_step);
            factor_x = sat_add(sat_add(factor_x, -drift),
                               fixed_mul(longint'(s1), shock_one));
            drift    = fixed_mul(fixed_mul(reversion_two, factor_y), time_step);
            factor_y = sat_add(sat_add(factor_y, -drift),
                               fixed_mul(longint'(s2), shock_two));

            rate = sat_add(sat_add(rate_start, factor_x), factor_y);
            if (rate < 0) rate = 0;

            want.rate     = rate[30:0];
            want.path_end = (step_count + 1 >= steps_per_path);
            if (want.path_end)
            begin
                factor_x   = 0;
                factor_y   = 0;
                step_count = 0;
                path_ends++;
            end
            else
            begin
                step_count = step_count + 1;
            end
            steps_seen++;
            rate_q.push_back(want);
        endfunction

        function void check_result(logic [30:0] rate, logic path_end);
            rate_result_t want;
            if (rate_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing owed: expected none, got rate %h last %b",
                         $time, rate, path_end);
                return;
            end
            want = rate_q.pop_front();
            if (rate !== want.rate)
            begin
                errors++;
                $display("%0t: short_rate mismatch: expected %h, got %h",
                         $time, want.rate, rate);
            end
            if (path_end !== want.path_end)
            begin
                errors++;
                $display("%0t: last_of_path mismatch: expected %b, got %b",
                         $time, want.path_end, path_end);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_stall;
    logic signed [31:0]         noise_one;
    logic signed [31:0]         noise_two;
    logic [30:0]                sigma_one;
    logic [30:0]                sigma_two;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [30:0]                short_rate;
    logic                       last_of_path;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [AddrW-1:0]           paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    logic                       quiet = 1'b0;
    int                         hold_left = 0;
    int                         settings_used = 0;

    short_rate_scoreboard sb = new();

    two_factor_short_rate_step uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .noise_one    (noise_one),
        .noise_two    (noise_two),
        .sigma_one    (sigma_one),
        .sigma_two    (sigma_two),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .short_rate   (short_rate),
        .last_of_path (last_of_path),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: bail out if the run hangs.
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("timeout after %0d cycles with %0d results outstanding",
                 LIMIT, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Monitor both handshakes on the pre-edge values. Inputs and the stall
    // are all driven with nonblocking assignments, so the sample is stable.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_item(noise_one, noise_two, sigma_one, sigma_two);
            if (result_valid && !result_stall)
                sb.check_result(short_rate, last_of_path);
        end
    end

    // Result back-pressure: random stall bursts, none once the run enters
    // its quiet tail.
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= $urandom_range(0, 7);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Register write: setup cycle, then access cycle until pready, then idle
    // so back-to-back writes each get a fresh setup.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] r0, input logic [31:0] k1,
                               input logic [31:0] k2, input logic [31:0] dt,
                               input logic [31:0] root_dt, input logic [31:0] rho,
                               input logic [31:0] rho_compl, input logic [31:0] steps);
        apb_write(REG_RATE_START,  r0);
        apb_write(REG_REVERSION_1, k1);
        apb_write(REG_REVERSION_2, k2);
        apb_write(REG_TIME_STEP,   dt);
        apb_write(REG_ROOT_STEP,   root_dt);
        apb_write(REG_CORR,        rho);
        apb_write(REG_CORR_COMPL,  rho_compl);
        apb_write(REG_STEPS,       steps);
        settings_used++;
    endtask

    // Offer one item; return once it has been taken. Before it, maybe drop
    // valid for a burst with junk on the payload.
    task automatic feed_item(input logic signed [31:0] n1, input logic signed [31:0] n2,
                             input logic [30:0] s1, input logic [30:0] s2);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            item_valid <= 1'b0;
            repeat (gap)
            begin
                noise_one <= $urandom;
                noise_two <= $urandom;
                sigma_one <= $urandom;
                sigma_two <= $urandom;
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        noise_one  <= n1;
        noise_two  <= n2;
        sigma_one  <= s1;
        sigma_two  <= s2;
        do @(posedge clk); while (item_stall);
    endtask

    // Drop valid and let every owed result come back, so the block is idle.
    task automatic end_phase();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Noise: mostly within +-4.0, sometimes any 32-bit pattern or a corner.
    function automatic logic signed [31:0] rand_noise();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 2))
                    0: v = N_MAX;
                    1: v = N_MIN;
                    default: v = '0;
                endcase
            end
            1, 2: v = $urandom;
            default:
            begin
                v = $urandom_range(0, 32'h4000_0000);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // Sigma: mostly up to 0.25, sometimes any 31-bit value or a corner.
    function automatic logic [30:0] rand_sigma();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = ($urandom_range(0, 1) == 1) ? {1'b0, S_MAX} : 32'd0;
            1, 2: v = $urandom;
            default: v = $urandom_range(0, 32'h0400_0000);
        endcase
        return v[30:0];
    endfunction

    // New register set for a random phase: plausible market values, an all-zero
    // corner with one-step paths, or raw bit patterns with junk above each register's width.
    task automatic random_config(input int mode);
        logic [31:0] rho;
        case (mode)
            0: load_config($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom,
                           ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 3));
            1: load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
            default:
            begin
                rho = $urandom_range(0, 32'h1000_0000);
                if ($urandom_range(0, 1) == 1) rho = -rho;
                load_config(($urandom_range(0, 3) == 0) ? -$urandom_range(0, 32'h0200_0000)
                                                        : $urandom_range(0, 32'h0200_0000),
                            $urandom_range(0, 32'h1000_0000),
                            $urandom_range(0, 32'h1000_0000),
                            $urandom_range(0, 32'h0400_0000),
                            $urandom_range(0, 32'h1000_0000),
                            rho,
                            $urandom_range(0, 32'h1000_0000),
                            $urandom_range(1, 12));
            end
        endcase
    endtask

    initial
    begin
        int ph;
        int mode;

        // Hold every input at a known value through reset.
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        noise_one  <= '0;
        noise_two  <= '0;
        sigma_one  <= '0;
        sigma_two  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nominal market: r0 3%, k1 0.1, k2 0.05, dt 1/16, rho -0.5, four-step paths.
        load_config(32'd8053064, 32'd26843546, 32'd13421773, 32'd16777216,
                    32'd67108864, 32'hF800_0000, 32'd232471924, 32'd4);
        feed_item('0, '0, '0, '0);
        feed_item(N_MAX, N_MAX, S_MAX, S_MAX);
        feed_item(N_MIN, N_MIN, S_MAX, S_MAX);
        feed_item(N_MIN, N_MAX, '0, S_MAX);
        feed_item(Q_ONE, -Q_ONE, 31'd2684355, 31'd5368709);
        feed_item(-Q_ONE, Q_ONE, 31'd2684355, 31'd5368709);
        end_phase();

        // Rate start at its bottom, each other register at its top, rho at +1,
        // zero path length: each step ends its path and the sums pin at the rails.
        load_config(N_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h1000_0000, 32'h1FFF_FFFF, 32'd0);
        feed_item(N_MAX, N_MIN, S_MAX, S_MAX);
        feed_item(N_MIN, N_MAX, S_MAX, S_MAX);
        feed_item(N_MAX, N_MAX, S_MAX, '0);
        feed_item(Q_ONE, Q_ONE, S_MAX, S_MAX);
        end_phase();

        // Top rate, rho at -1, longest possible path.
        apb_write(REG_RATE_START, N_MAX);
        apb_write(REG_CORR, 32'hF000_0000);
        apb_write(REG_STEPS, 32'hFFFF_FFFF);
        settings_used++;
        feed_item(Q_ONE, N_MIN, S_MAX, S_MAX);
        feed_item(-Q_ONE, N_MAX, S_MAX, S_MAX);
        feed_item('0, Q_ONE, '0, S_MAX);
        end_phase();

        // Shorten the path twice mid-way; the second cut lands below the
        // running count, so the next step must close the path.
        apb_write(REG_STEPS, 32'd10);
        feed_item(Q_ONE, Q_ONE, 31'd2684355, 31'd2684355);
        feed_item(-Q_ONE, Q_ONE, 31'd2684355, 31'd2684355);
        feed_item(Q_ONE, -Q_ONE, 31'd2684355, 31'd2684355);
        end_phase();
        apb_write(REG_STEPS, 32'd2);
        settings_used++;
        feed_item(Q_ONE, Q_ONE, S_MAX, S_MAX);
        end_phase();

        // Random phases; the last one runs with no idling on either side.
        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 1 || ph == 5)
                mode = 0;
            else if (ph == 3)
                mode = 1;
            else
                mode = 2;
            random_config(mode);
            if (ph == 7) quiet = 1'b1;
            repeat (50) feed_item(rand_noise(), rand_noise(), rand_sigma(), rand_sigma());
            end_phase();
        end

        // Let any late result surface before judging.
        repeat (DRAIN) @(posedge clk);

        $display("Ran %0d rate steps, %0d of them closing a path, under %0d register settings",
                 sb.steps_seen, sb.path_ends, settings_used);
        $display("(%0d register writes); %0d mismatches seen", sb.reg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
